FILE: rtl/core/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// shared types and codes of the graph cycle detector: operations, status
// codes, sequencer states and the control bundles between its units
// ----------------------------------------------------------------------------
package gcd_pkg;

   // width of counts and node indices carried on the ports
   localparam int CNT_W = 7;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_EDGE  = 2'd1,
      OP_EVAL  = 2'd2,
      OP_NONE  = 2'd3
   } gcd_op_type;

   typedef enum logic [1:0] {
      STATUS_ACYCLIC    = 2'd0,
      STATUS_CYCLE      = 2'd1,
      STATUS_UNRESOLVED = 2'd2,
      STATUS_RSVD       = 2'd3
   } gcd_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_WR,
      S_SEED_RD,
      S_SEED_UPD,
      S_POP,
      S_POP_WAIT,
      S_ROW_WAIT,
      S_SCAN,
      S_SCAN_UPD,
      S_DONE
   } gcd_state_type;

   // graph store strobes
   typedef struct packed {
      logic clear;
      logic row_rd;
      logic row_wr;
      logic deg_rd;
      logic deg_wr;
   } gcd_store_ctl_type;

   // walk memory strobes
   typedef struct packed {
      logic work_rd;
      logic work_wr;
      logic q_rd;
      logic q_wr;
   } gcd_walk_ctl_type;

   typedef struct packed {
      logic           valid;
      gcd_status_type status;
      logic [CNT_W-1:0] visited;
   } gcd_result_type;

endpackage

FILE: rtl/core/graph_cycle_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_cycle_detector_core
// loads a directed graph edge by edge and checks it for cycles with a
// topological walk
// ----------------------------------------------------------------------------
// usage:
//   req channel carries commands: begin (clear graph, set node count),
//   add edge, evaluate. only evaluate produces a beat on the rsp channel,
//   carrying status (acyclic, cycle, unresolved edge) and visited count.
//   steps per request beat:
//     begin     clears the graph and sets the node count
//     add edge  reads row and in-degree, then writes both back unless the
//               edge is a duplicate; no memory access when not a link or out of range
//     evaluate  copies the in-degrees, then pops each ready node, reads its
//               row and decrements the in-degree of each successor; the single
//               in-degree decrement unit and the one-port memories take one
//               successor at a time; with an unresolved edge pending it answers at once
//   req_tready is high only while the sequencer is idle.
//   a finished result sits in the rsp output register; further begin and
//   edge beats are taken meanwhile, an evaluate waits at its end until the
//   register is free, so a stalled receiver loses nothing.
//   reset empties the graph, sets node count to zero and drops any
//   pending response.
// ----------------------------------------------------------------------------
module graph_cycle_detector_core #(
   parameter int MAX_NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] num_nodes, [13:7] from_node, [20:14] to_node, [23:21] zero
   input  logic [23:0] req_tdata,
   // [1:0] operation, [2] is_node_link
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [8:2] visited_count, [15:9] zero
   output logic [15:0] rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CW    = gcd_pkg::CNT_W;

   // request fields
   logic [CW-1:0]       req_num_nodes;
   logic [CW-1:0]       req_from_node;
   logic [CW-1:0]       req_to_node;
   gcd_pkg::gcd_op_type req_operation;
   logic                req_is_node_link;
   logic                req_beat;

   assign req_num_nodes    = req_tdata[6:0];
   assign req_from_node    = req_tdata[13:7];
   assign req_to_node      = req_tdata[20:14];
   assign req_operation    = gcd_pkg::gcd_op_type'(req_tuser[1:0]);
   assign req_is_node_link = req_tuser[2];

   logic seq_idle;
   assign req_tready = seq_idle;
   assign req_beat   = req_tvalid && req_tready;

   // output register
   logic                    rsp_valid_ff;
   gcd_pkg::gcd_status_type rsp_status_ff;
   logic [CW-1:0]           rsp_visited_ff;
   logic                    rsp_free;
   gcd_pkg::gcd_result_type seq_result;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_result.valid) begin
         rsp_status_ff  <= seq_result.status;
         rsp_visited_ff <= seq_result.visited;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_visited_ff, rsp_status_ff};

   // memory connections
   gcd_pkg::gcd_store_ctl_type st_ctl;
   gcd_pkg::gcd_walk_ctl_type  wk_ctl;
   logic [IDX_W-1:0]     row_addr;
   logic [MAX_NODES-1:0] row_wdata;
   logic [MAX_NODES-1:0] row_rdata;
   logic [IDX_W-1:0]     deg_addr;
   logic [CW-1:0]        deg_wdata;
   logic [CW-1:0]        deg_rdata;
   logic [IDX_W-1:0]     work_addr;
   logic [CW-1:0]        work_wdata;
   logic [CW-1:0]        work_rdata;
   logic [IDX_W-1:0]     q_wr_addr;
   logic [IDX_W-1:0]     q_rd_addr;
   logic [IDX_W-1:0]     q_wdata;
   logic [IDX_W-1:0]     q_rdata;

   gcd_sequencer #(
      .MAX_NODES (MAX_NODES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .in_beat       (req_beat),
      .in_op         (req_operation),
      .in_num_nodes  (req_num_nodes),
      .in_from       (req_from_node),
      .in_to         (req_to_node),
      .in_link       (req_is_node_link),
      .idle          (seq_idle),
      .rsp_free      (rsp_free),
      .result        (seq_result),
      .st_ctl        (st_ctl),
      .row_addr      (row_addr),
      .row_wdata     (row_wdata),
      .row_rdata     (row_rdata),
      .deg_addr      (deg_addr),
      .deg_wdata     (deg_wdata),
      .deg_rdata     (deg_rdata),
      .wk_ctl        (wk_ctl),
      .work_addr     (work_addr),
      .work_wdata    (work_wdata),
      .work_rdata    (work_rdata),
      .q_wr_addr     (q_wr_addr),
      .q_rd_addr     (q_rd_addr),
      .q_wdata       (q_wdata),
      .q_rdata       (q_rdata)
   );

   // adjacency rows and in-degrees
   gcd_graph_store #(
      .MAX_NODES (MAX_NODES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (st_ctl),
      .row_addr  (row_addr),
      .row_wdata (row_wdata),
      .row_rdata (row_rdata),
      .deg_addr  (deg_addr),
      .deg_wdata (deg_wdata),
      .deg_rdata (deg_rdata)
   );

   // working in-degrees and ready queue
   gcd_walk_mem #(
      .MAX_NODES (MAX_NODES)
   ) u_walk (
      .clock      (clock),
      .ctl        (wk_ctl),
      .work_addr  (work_addr),
      .work_wdata (work_wdata),
      .work_rdata (work_rdata),
      .q_wr_addr  (q_wr_addr),
      .q_rd_addr  (q_rd_addr),
      .q_wdata    (q_wdata),
      .q_rdata    (q_rdata)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_result.valid |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten while stalled");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_operation == gcd_pkg::OP_EVAL) |=> !req_tready)
      else $error("request taken during evaluation");

   a_rsp_only_after_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(seq_result.valid))
      else $error("response without evaluation result");

endmodule

FILE: rtl/core/gcd_graph_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_graph_store
// adjacency matrix rows and in-degree counters, one port each, with per-entry
// valid bits so a clear resets only the valid bits
// ----------------------------------------------------------------------------
module gcd_graph_store #(
   parameter int MAX_NODES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gcd_pkg::gcd_store_ctl_type   ctl,
   input  logic [$clog2(MAX_NODES)-1:0] row_addr,
   input  logic [MAX_NODES-1:0]         row_wdata,
   output logic [MAX_NODES-1:0]         row_rdata,
   input  logic [$clog2(MAX_NODES)-1:0] deg_addr,
   input  logic [gcd_pkg::CNT_W-1:0]    deg_wdata,
   output logic [gcd_pkg::CNT_W-1:0]    deg_rdata
);

   logic [MAX_NODES-1:0]      row_mem [MAX_NODES];
   logic [gcd_pkg::CNT_W-1:0] deg_mem [MAX_NODES];

   logic [MAX_NODES-1:0]      row_vld_ff;
   logic [MAX_NODES-1:0]      deg_vld_ff;
   logic [MAX_NODES-1:0]      row_q_ff;
   logic [gcd_pkg::CNT_W-1:0] deg_q_ff;
   logic                      row_qv_ff;
   logic                      deg_qv_ff;

   // memory arrays
   always_ff @(posedge clock) begin
      if (ctl.row_wr) begin
         row_mem[row_addr] <= row_wdata;
      end
      if (ctl.row_rd) begin
         row_q_ff <= row_mem[row_addr];
      end
      if (ctl.deg_wr) begin
         deg_mem[deg_addr] <= deg_wdata;
      end
      if (ctl.deg_rd) begin
         deg_q_ff <= deg_mem[deg_addr];
      end
   end

   // valid bits, an invalid entry reads as zero
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         row_vld_ff <= '0;
         deg_vld_ff <= '0;
         row_qv_ff  <= 1'b0;
         deg_qv_ff  <= 1'b0;
      end else begin
         if (ctl.row_wr) begin
            row_vld_ff[row_addr] <= 1'b1;
         end
         if (ctl.deg_wr) begin
            deg_vld_ff[deg_addr] <= 1'b1;
         end
         if (ctl.row_rd) begin
            row_qv_ff <= row_vld_ff[row_addr];
         end
         if (ctl.deg_rd) begin
            deg_qv_ff <= deg_vld_ff[deg_addr];
         end
      end
   end

   assign row_rdata = row_qv_ff ? row_q_ff : '0;
   assign deg_rdata = deg_qv_ff ? deg_q_ff : '0;

endmodule

FILE: rtl/core/gcd_walk_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_walk_mem
// working in-degree copy and ready queue used during one evaluation
// ----------------------------------------------------------------------------
module gcd_walk_mem #(
   parameter int MAX_NODES = 64
) (
   input  logic                         clock,
   input  gcd_pkg::gcd_walk_ctl_type    ctl,
   input  logic [$clog2(MAX_NODES)-1:0] work_addr,
   input  logic [gcd_pkg::CNT_W-1:0]    work_wdata,
   output logic [gcd_pkg::CNT_W-1:0]    work_rdata,
   input  logic [$clog2(MAX_NODES)-1:0] q_wr_addr,
   input  logic [$clog2(MAX_NODES)-1:0] q_rd_addr,
   input  logic [$clog2(MAX_NODES)-1:0] q_wdata,
   output logic [$clog2(MAX_NODES)-1:0] q_rdata
);

   logic [gcd_pkg::CNT_W-1:0]    work_mem  [MAX_NODES];
   logic [$clog2(MAX_NODES)-1:0] queue_mem [MAX_NODES];

   always_ff @(posedge clock) begin
      if (ctl.work_wr) begin
         work_mem[work_addr] <= work_wdata;
      end
      if (ctl.work_rd) begin
         work_rdata <= work_mem[work_addr];
      end
      if (ctl.q_wr) begin
         queue_mem[q_wr_addr] <= q_wdata;
      end
      if (ctl.q_rd) begin
         q_rdata <= queue_mem[q_rd_addr];
      end
   end

endmodule

FILE: rtl/core/gcd_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sequencer
// control of edge loading and of the walk; one decrement-and-test unit
// handles one in-degree per step
// ----------------------------------------------------------------------------
module gcd_sequencer #(
   parameter int MAX_NODES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_beat,
   input  gcd_pkg::gcd_op_type          in_op,
   input  logic [gcd_pkg::CNT_W-1:0]    in_num_nodes,
   input  logic [gcd_pkg::CNT_W-1:0]    in_from,
   input  logic [gcd_pkg::CNT_W-1:0]    in_to,
   input  logic                         in_link,
   output logic                         idle,
   input  logic                         rsp_free,
   output gcd_pkg::gcd_result_type      result,
   output gcd_pkg::gcd_store_ctl_type   st_ctl,
   output logic [$clog2(MAX_NODES)-1:0] row_addr,
   output logic [MAX_NODES-1:0]         row_wdata,
   input  logic [MAX_NODES-1:0]         row_rdata,
   output logic [$clog2(MAX_NODES)-1:0] deg_addr,
   output logic [gcd_pkg::CNT_W-1:0]    deg_wdata,
   input  logic [gcd_pkg::CNT_W-1:0]    deg_rdata,
   output gcd_pkg::gcd_walk_ctl_type    wk_ctl,
   output logic [$clog2(MAX_NODES)-1:0] work_addr,
   output logic [gcd_pkg::CNT_W-1:0]    work_wdata,
   input  logic [gcd_pkg::CNT_W-1:0]    work_rdata,
   output logic [$clog2(MAX_NODES)-1:0] q_wr_addr,
   output logic [$clog2(MAX_NODES)-1:0] q_rd_addr,
   output logic [$clog2(MAX_NODES)-1:0] q_wdata,
   input  logic [$clog2(MAX_NODES)-1:0] q_rdata
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int PTR_W = IDX_W + 1;
   localparam int CW    = gcd_pkg::CNT_W;

   gcd_pkg::gcd_state_type state_ff, state_in;
   gcd_pkg::gcd_status_type status_ff, status_in;
   logic [CW-1:0]        active_ff, active_in;
   logic                 error_ff, error_in;
   logic [IDX_W-1:0]     from_ff, from_in;
   logic [IDX_W-1:0]     to_ff, to_in;
   logic [PTR_W-1:0]     idx_ff, idx_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [MAX_NODES-1:0] row_ff, row_in;
   logic [CW-1:0]        visited_ff, visited_in;

   logic [CW-1:0]        count_sat;
   logic [MAX_NODES-1:0] edge_bit;
   logic [CW-1:0]        work_dec;
   logic                 room;

   assign count_sat = (in_num_nodes > CW'(MAX_NODES)) ? CW'(MAX_NODES) : in_num_nodes;
   assign edge_bit  = MAX_NODES'(1) << to_ff;
   // shared decrement unit, saturating at zero
   assign work_dec  = (work_rdata != '0) ? work_rdata - CW'(1) : work_rdata;
   assign room      = tail_ff < PTR_W'(MAX_NODES);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gcd_pkg::S_IDLE;
         active_ff  <= '0;
         error_ff   <= 1'b0;
         head_ff    <= '0;
         tail_ff    <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         error_ff   <= error_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff    <= from_in;
      to_ff      <= to_in;
      row_ff     <= row_in;
      status_ff  <= status_in;
      visited_ff <= visited_in;
   end

   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      error_in   = error_ff;
      from_in    = from_ff;
      to_in      = to_ff;
      idx_in     = idx_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      row_in     = row_ff;
      status_in  = status_ff;
      visited_in = visited_ff;
      st_ctl     = '0;
      wk_ctl     = '0;
      row_addr   = from_ff;
      row_wdata  = row_rdata | edge_bit;
      deg_addr   = to_ff;
      deg_wdata  = deg_rdata + CW'(1);
      work_addr  = idx_ff[IDX_W-1:0];
      work_wdata = deg_rdata;
      q_wr_addr  = tail_ff[IDX_W-1:0];
      q_rd_addr  = head_ff[IDX_W-1:0];
      q_wdata    = idx_ff[IDX_W-1:0];
      result     = '0;
      idle       = 1'b0;

      case (state_ff)
         gcd_pkg::S_IDLE: begin
            idle = 1'b1;
            if (in_beat) begin
               case (in_op)
                  gcd_pkg::OP_BEGIN: begin
                     st_ctl.clear = 1'b1;
                     active_in    = count_sat;
                     error_in     = 1'b0;
                     head_in      = '0;
                     tail_in      = '0;
                  end
                  gcd_pkg::OP_EDGE: begin
                     if (in_link) begin
                        if (in_from >= active_ff || in_to >= active_ff) begin
                           error_in = 1'b1;
                        end else begin
                           from_in       = in_from[IDX_W-1:0];
                           to_in         = in_to[IDX_W-1:0];
                           row_addr      = in_from[IDX_W-1:0];
                           deg_addr      = in_to[IDX_W-1:0];
                           st_ctl.row_rd = 1'b1;
                           st_ctl.deg_rd = 1'b1;
                           state_in      = gcd_pkg::S_EDGE_WR;
                        end
                     end
                  end
                  gcd_pkg::OP_EVAL: begin
                     if (error_ff) begin
                        status_in  = gcd_pkg::STATUS_UNRESOLVED;
                        visited_in = '0;
                        state_in   = gcd_pkg::S_DONE;
                     end else begin
                        head_in  = '0;
                        tail_in  = '0;
                        idx_in   = '0;
                        state_in = gcd_pkg::S_SEED_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // duplicate edges leave row and count alone
         gcd_pkg::S_EDGE_WR: begin
            if ((row_rdata & edge_bit) == '0) begin
               st_ctl.row_wr = 1'b1;
               st_ctl.deg_wr = 1'b1;
            end
            state_in = gcd_pkg::S_IDLE;
         end
         // copy in-degrees and queue the zero ones
         gcd_pkg::S_SEED_RD: begin
            if (CW'(idx_ff) < active_ff) begin
               deg_addr      = idx_ff[IDX_W-1:0];
               st_ctl.deg_rd = 1'b1;
               state_in      = gcd_pkg::S_SEED_UPD;
            end else begin
               state_in = gcd_pkg::S_POP;
            end
         end
         gcd_pkg::S_SEED_UPD: begin
            wk_ctl.work_wr = 1'b1;
            if (deg_rdata == '0 && room) begin
               wk_ctl.q_wr = 1'b1;
               tail_in     = tail_ff + PTR_W'(1);
            end
            idx_in   = idx_ff + PTR_W'(1);
            state_in = gcd_pkg::S_SEED_RD;
         end
         gcd_pkg::S_POP: begin
            if (head_ff < tail_ff) begin
               wk_ctl.q_rd = 1'b1;
               head_in     = head_ff + PTR_W'(1);
               state_in    = gcd_pkg::S_POP_WAIT;
            end else begin
               status_in  = (CW'(head_ff) == active_ff) ? gcd_pkg::STATUS_ACYCLIC
                                                        : gcd_pkg::STATUS_CYCLE;
               visited_in = CW'(head_ff);
               state_in   = gcd_pkg::S_DONE;
            end
         end
         gcd_pkg::S_POP_WAIT: begin
            row_addr      = q_rdata;
            st_ctl.row_rd = 1'b1;
            state_in      = gcd_pkg::S_ROW_WAIT;
         end
         gcd_pkg::S_ROW_WAIT: begin
            row_in   = row_rdata;
            idx_in   = '0;
            state_in = gcd_pkg::S_SCAN;
         end
         // successors of the popped node, lowest index first
         gcd_pkg::S_SCAN: begin
            if (CW'(idx_ff) >= active_ff) begin
               state_in = gcd_pkg::S_POP;
            end else if (row_ff[0]) begin
               wk_ctl.work_rd = 1'b1;
               state_in       = gcd_pkg::S_SCAN_UPD;
            end else begin
               row_in = row_ff >> 1;
               idx_in = idx_ff + PTR_W'(1);
            end
         end
         gcd_pkg::S_SCAN_UPD: begin
            wk_ctl.work_wr = 1'b1;
            work_wdata     = work_dec;
            if (work_dec == '0 && room) begin
               wk_ctl.q_wr = 1'b1;
               tail_in     = tail_ff + PTR_W'(1);
            end
            row_in   = row_ff >> 1;
            idx_in   = idx_ff + PTR_W'(1);
            state_in = gcd_pkg::S_SCAN;
         end
         gcd_pkg::S_DONE: begin
            if (rsp_free) begin
               result.valid   = 1'b1;
               result.status  = status_ff;
               result.visited = visited_ff;
               state_in       = gcd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gcd_pkg::S_IDLE;
         end
      endcase
   end

   a_head_behind_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= PTR_W'(MAX_NODES) && active_ff <= CW'(MAX_NODES))
      else $error("queue tail or node count out of range");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcd_pkg::S_DONE && !rsp_free) |=> state_ff == gcd_pkg::S_DONE)
      else $error("result dropped while output busy");

   a_visited_bound: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> result.visited <= active_ff)
      else $error("visited count exceeds node count");

endmodule

FILE: dv/tb_graph_cycle_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_cycle_detector_core
// self-checking bench for the graph cycle detector: loads graphs edge by edge
// over the req stream, runs a local topological walk on every evaluate beat
// and checks status and visited count on the rsp stream, with bursty requests
// and a stalling receiver
// ----------------------------------------------------------------------------
module tb_graph_cycle_detector_core;

   localparam int GRAPH_NODES  = 64;
   localparam int RANDOM_ITEMS = 450;
   // slowest legal run stays well below this, even with 64 node walks
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      gcd_pkg::gcd_op_type op;
      logic [6:0] num_nodes;
      logic [6:0] from_node;
      logic [6:0] to_node;
      logic       is_link;
      bit         drain;      // hold this beat until every result is back
   } graph_cmd_type;

   typedef struct {
      gcd_pkg::gcd_status_type status;
      logic [6:0]     visited;
      int             stamp;  // cycle the evaluate beat was taken
   } walk_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [6:0] num_nodes, [13:7] from_node, [20:14] to_node, [23:21] zero
   logic [23:0] req_tdata = '0;
   // [1:0] operation, [2] is_node_link
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [1:0] status, [8:2] visited_count, [15:9] zero
   logic [15:0] rsp_tdata;

   graph_cycle_detector_core #(
      .MAX_NODES(GRAPH_NODES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // graph shadow: adjacency bits, in-degrees, node count, sticky error
   // --------------------------------------------------------------------------
   logic [63:0] shadow_rows   [GRAPH_NODES];
   logic [6:0]  shadow_indeg  [GRAPH_NODES];
   int unsigned shadow_nodes;
   bit          shadow_unresolved;

   graph_cmd_type   pending_cmds[$];
   walk_result_type walk_results_q[$];

   int cycle_count   = 0;
   int error_count   = 0;
   int cmds_accepted = 0;
   int total_cmds    = 0;
   int evals_sent    = 0;
   int results_seen  = 0;
   int counted_items = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic void clear_shadow();
      foreach (shadow_rows[i]) begin
         shadow_rows[i]  = '0;
         shadow_indeg[i] = '0;
      end
      shadow_unresolved = 1'b0;
   endfunction

   // topological walk over a working copy of the in-degrees, graph left intact
   function automatic void topo_walk(output gcd_pkg::gcd_status_type st,
                                     output logic [6:0] visited);
      logic [6:0] work  [GRAPH_NODES];
      logic [5:0] order [GRAPH_NODES];
      int head;
      int tail;
      int u;
      head = 0;
      tail = 0;
      foreach (work[i]) work[i] = shadow_indeg[i];
      for (int i = 0; i < shadow_nodes; i++) begin
         if (work[i] == 0 && tail < GRAPH_NODES) begin
            order[tail] = 6'(i);
            tail++;
         end
      end
      while (head < tail) begin
         u = int'(order[head]);
         head++;
         for (int v = 0; v < shadow_nodes; v++) begin
            if (shadow_rows[u][v]) begin
               if (work[v] > 0) work[v]--;
               if (work[v] == 0 && tail < GRAPH_NODES) begin
                  order[tail] = 6'(v);
                  tail++;
               end
            end
         end
      end
      visited = head[6:0];
      st = (head == shadow_nodes) ? gcd_pkg::STATUS_ACYCLIC : gcd_pkg::STATUS_CYCLE;
   endfunction

   // applies one accepted beat to the shadow, returns 1 when a result follows
   function automatic bit predict_graph_beat(input graph_cmd_type cmd,
                                             output walk_result_type res);
      bit has_result;
      has_result = 1'b0;
      res.status  = gcd_pkg::STATUS_ACYCLIC;
      res.visited = '0;
      res.stamp   = cycle_count;
      case (cmd.op)
         gcd_pkg::OP_BEGIN: begin
            clear_shadow();
            shadow_nodes = (cmd.num_nodes > GRAPH_NODES) ? GRAPH_NODES : cmd.num_nodes;
         end
         gcd_pkg::OP_EDGE: begin
            if (cmd.is_link) begin
               if (cmd.from_node >= shadow_nodes || cmd.to_node >= shadow_nodes) begin
                  shadow_unresolved = 1'b1;
               end else if (!shadow_rows[cmd.from_node][cmd.to_node]) begin
                  // duplicates are stored and counted once
                  shadow_rows[cmd.from_node][cmd.to_node] = 1'b1;
                  shadow_indeg[cmd.to_node] = shadow_indeg[cmd.to_node] + 7'd1;
               end
            end
         end
         gcd_pkg::OP_EVAL: begin
            has_result = 1'b1;
            if (shadow_unresolved) begin
               res.status = gcd_pkg::STATUS_UNRESOLVED;
            end else begin
               topo_walk(res.status, res.visited);
            end
         end
         default: ;
      endcase
      return has_result;
   endfunction

   // --------------------------------------------------------------------------
   // command list building
   // --------------------------------------------------------------------------
   task automatic add_cmd(input gcd_pkg::gcd_op_type op, input int count, input int from,
                          input int to, input int link, input bit drain = 1'b0);
      graph_cmd_type c;
      c.op         = op;
      c.num_nodes  = count[6:0];
      c.from_node  = from[6:0];
      c.to_node    = to[6:0];
      c.is_link    = link[0];
      c.drain      = drain;
      pending_cmds.push_back(c);
      counted_items++;
   endtask

   task automatic add_link(input int from, input int to);
      add_cmd(gcd_pkg::OP_EDGE, $urandom, from, to, 1);
   endtask

   task automatic add_eval();
      add_cmd(gcd_pkg::OP_EVAL, $urandom, $urandom, $urandom, $urandom_range(0, 1));
   endtask

   task automatic build_directed();
      add_eval();                                   // empty graph straight out of reset
      // saturates to 64
      add_cmd(gcd_pkg::OP_BEGIN, 127, $urandom, $urandom, $urandom_range(0, 1));
      add_cmd(gcd_pkg::OP_EDGE, $urandom, 127, 127, 0);   // non-link edge, ignored
      add_link(63, 0);
      add_link(0, 63);
      add_cmd(gcd_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      add_eval();                                   // two node cycle at the extremes
      add_eval();                                   // graph survives the walk
      add_cmd(gcd_pkg::OP_BEGIN, 3, $urandom, $urandom, $urandom_range(0, 1));
      add_link(0, 1);
      add_link(1, 2);
      add_link(0, 1);                               // duplicate
      add_eval();
      add_link(2, 2);                               // self loop
      add_eval();
      add_link(1, 127);                             // target out of range
      add_eval();
      add_eval();                                   // error is sticky
      add_cmd(gcd_pkg::OP_BEGIN, 2, $urandom, $urandom, $urandom_range(0, 1));
      add_link(0, 1);
      add_link(1, 0);
      add_eval();
      add_cmd(gcd_pkg::OP_BEGIN, 0, $urandom, $urandom, $urandom_range(0, 1));
      add_link(0, 0);                               // any edge is out of range here
      add_eval();
      add_cmd(gcd_pkg::OP_BEGIN, 1, $urandom, $urandom, $urandom_range(0, 1));
      add_eval();
   endtask

   // one begin, a run of edges shaped by mode, then mostly one or two evaluates
   task automatic build_random_graph(input bit force_drain);
      int n;
      int pick;
      int mode;      // 0 acyclic, 1 free form, 2 ring then acyclic
      bit flip;
      int edges;
      int ring_len;
      int ring_base;
      int a;
      int b;
      int last_from;
      int last_to;
      pick = $urandom_range(0, 99);
      if (pick < 4)       n = 0;
      else if (pick < 9)  n = $urandom_range(64, 127);
      else if (pick < 13) n = 1;
      else                n = $urandom_range(2, 12);
      add_cmd(gcd_pkg::OP_BEGIN, n, $urandom, $urandom, $urandom_range(0, 1),
              force_drain || ($urandom_range(0, 9) == 0));
      if (n > GRAPH_NODES) n = GRAPH_NODES;
      pick = $urandom_range(0, 99);
      mode = (pick < 50) ? 0 : (pick < 85) ? 1 : 2;
      flip = $urandom_range(0, 1);
      edges = (n >= GRAPH_NODES) ? $urandom_range(0, 40) : $urandom_range(0, 3 * n + 2);
      if (edges > 30) edges = (n >= GRAPH_NODES) ? edges : 30;
      ring_len  = (n == 0) ? 0 : $urandom_range(1, (n < 6) ? n : 6);
      ring_base = (n == 0) ? 0 : $urandom_range(0, n - ring_len);
      last_from = 0;
      last_to   = 0;
      for (int k = 0; k < edges; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            add_cmd(gcd_pkg::OP_EDGE, $urandom, $urandom_range(0, 127),
                    $urandom_range(0, 127), 0);
         end else if (pick < 9 || n == 0) begin
            // at least one endpoint at or beyond the node count
            a = $urandom_range(n, 127);
            b = (n == 0 || $urandom_range(0, 1)) ? $urandom_range(n, 127) : $urandom_range(0, n - 1);
            if ($urandom_range(0, 1)) add_link(a, b);
            else                      add_link(b, a);
         end else if (pick < 12) begin
            add_cmd(gcd_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom_range(0, 1));
         end else if (pick < 17 && k > 0) begin
            add_link(last_from, last_to);
         end else if (pick < 20) begin
            add_eval();                             // mid-load evaluate
         end else begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            if (mode == 2 && k < ring_len) begin
               a = ring_base + k;
               b = ring_base + (k + 1) % ring_len;
            end else if (mode != 1) begin
               if (a == b && n > 1) b = (a + 1) % n;
               if ((a > b) != flip) begin
                  pick = a;
                  a = b;
                  b = pick;
               end
            end
            add_link(a, b);
            last_from = a;
            last_to   = b;
         end
      end
      if ($urandom_range(0, 19) != 0) add_eval();
      if ($urandom_range(0, 9) == 0)  add_eval();
   endtask

   // --------------------------------------------------------------------------
   // cycle counter and watchdog
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // request driver: bursts of beats with random gaps, fed from pending_cmds
   // --------------------------------------------------------------------------
   graph_cmd_type   cur_cmd;
   walk_result_type new_result;
   int              burst_left = 0;
   int              gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         // beat taken at this edge: update the shadow and queue the result
         if (req_tvalid && req_tready) begin
            cmds_accepted++;
            if (predict_graph_beat(cur_cmd, new_result)) begin
               walk_results_q.push_back(new_result);
               evals_sent++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_cmds[0].drain && evals_sent != results_seen) begin
               // hold off until the receiver has every outstanding result
               req_tvalid <= 1'b0;
            end else begin
               cur_cmd = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, cur_cmd.to_node, cur_cmd.from_node, cur_cmd.num_nodes};
               req_tuser  <= {cur_cmd.is_link, cur_cmd.op};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // some bursts run back to back, some long ones have no gaps at all
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(0, 8);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     1:       gap_left = $urandom_range(1, 2);
                     2:       gap_left = $urandom_range(3, 8);
                     default: gap_left = $urandom_range(9, 20);
                  endcase
               end
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // response monitor and receiver stalls
   // --------------------------------------------------------------------------
   walk_result_type want;
   int              stall_left = 0;
   bit              stalling   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            // an evaluate taken at this same edge cannot have answered yet
            if (walk_results_q.size() == 0 || walk_results_q[0].stamp == cycle_count) begin
               report_mismatch($sformatf("result with no evaluate pending, data %h", rsp_tdata));
            end else begin
               want = walk_results_q.pop_front();
               if (rsp_tdata[1:0] !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_tdata[1:0], want.status));
               if (rsp_tdata[8:2] !== want.visited)
                  report_mismatch($sformatf("visited_count got %0d want %0d",
                                            rsp_tdata[8:2], want.visited));
            end
         end
         // alternating ready and stall runs of random length
         if (stall_left > 0) begin
            stall_left--;
         end else begin
            stalling   = !stalling;
            stall_left = stalling ? (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 25))
                                  : $urandom_range(1, 30);
         end
         rsp_tready <= !stalling;
      end
   end

   // --------------------------------------------------------------------------
   // stimulus build, reset and end of run
   // --------------------------------------------------------------------------
   initial begin
      clear_shadow();
      shadow_nodes = 0;
      build_directed();
      build_random_graph(1'b1);
      while (counted_items < RANDOM_ITEMS) build_random_graph(1'b0);
      total_cmds = pending_cmds.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmds_accepted != total_cmds) @(negedge clock);
      while (walk_results_q.size() != 0) @(negedge clock);
      // let any stray beat show up before the verdict
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
